// File: src/pse_pkg.sv
`default_nettype none
package pse_pkg;

   localparam int DEPTH       = 64;
   localparam int WORD_BITS   = 32;
   localparam int ADDR_BITS   = $clog2(DEPTH);
   localparam int CNT_BITS    = $clog2(DEPTH + 1);
   localparam int CMD_BITS    = 3;
   localparam int VALUE_BITS  = 32;
   localparam int POS_BITS    = 7;
   localparam int AMT_BITS    = 7;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 7;
   localparam int CMP_BITS    = ((CNT_BITS > POS_BITS) ? CNT_BITS : POS_BITS) + 1;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_INSERT = 3'd2,
      CMD_DELETE = 3'd3,
      CMD_SEARCH = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_BAD_POS = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_PUSH,
      ACT_POP,
      ACT_DEL_TOP,
      ACT_INS_INIT,
      ACT_INS_RD,
      ACT_INS_WR,
      ACT_INS_PLACE,
      ACT_DEL_INIT,
      ACT_DEL_RD,
      ACT_DEL_WR,
      ACT_DEL_END,
      ACT_SCAN_INIT,
      ACT_SCAN_RD,
      ACT_SCAN_CMP,
      ACT_TOP_RD,
      ACT_RSP
   } act_type;

   typedef struct packed {
      act_type act;
   } ctl_cmd_type;

   typedef struct packed {
      logic [CMD_BITS-1:0] cmd;
      logic                ok;
      logic                pos_one;
      logic                idx_ge_pos;
      logic                idx_lt_count;
      logic                rsp_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// File: src/pse_req_if.sv
`default_nettype none
interface pse_req_if;
   logic                                   valid;
   logic                                   ready;
   logic        [pse_pkg::CMD_BITS-1:0]    command;
   logic signed [pse_pkg::VALUE_BITS-1:0]  value;
   logic        [pse_pkg::POS_BITS-1:0]    position;
   logic        [pse_pkg::AMT_BITS-1:0]    amount;

   modport source (output valid, command, value, position, amount, input ready);
   modport sink   (input valid, command, value, position, amount, output ready);
endinterface
`default_nettype wire

// File: src/pse_rsp_if.sv
`default_nettype none
interface pse_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [pse_pkg::STATUS_BITS-1:0] status;
   logic                                   found;
   logic        [pse_pkg::COUNT_BITS-1:0]  entry_count;
   logic signed [pse_pkg::VALUE_BITS-1:0]  top_value;

   modport source (output valid, status, found, entry_count, top_value, input ready);
   modport sink   (input valid, status, found, entry_count, top_value, output ready);
endinterface
`default_nettype wire

// File: src/pse_ctrl.sv
`default_nettype none
module pse_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  pse_pkg::dp_stat_type       dp_stat,
   output pse_pkg::ctl_cmd_type       dp_cmd
);
   import pse_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE     = 13'b0000000000001,
      S_EXEC     = 13'b0000000000010,
      S_INS_RD   = 13'b0000000000100,
      S_INS_WR   = 13'b0000000001000,
      S_DEL_RD   = 13'b0000000010000,
      S_DEL_WR   = 13'b0000000100000,
      S_SCAN_RD  = 13'b0000001000000,
      S_SCAN_CMP = 13'b0000010000000,
      S_TOP      = 13'b0000100000000,
      S_DONE     = 13'b0001000000000,
      S_SPARE_A  = 13'b0010000000000,
      S_SPARE_B  = 13'b0100000000000,
      S_SPARE_C  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      dp_cmd.act = ACT_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.act = ACT_LOAD;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_TOP;
            if (dp_stat.ok) begin
               unique case (dp_stat.cmd)
                  CMD_PUSH: dp_cmd.act = ACT_PUSH;
                  CMD_POP:  dp_cmd.act = ACT_POP;
                  CMD_INSERT: begin
                     if (dp_stat.pos_one) begin
                        dp_cmd.act = ACT_PUSH;
                     end else begin
                        dp_cmd.act = ACT_INS_INIT;
                        state_in   = S_INS_RD;
                     end
                  end
                  CMD_DELETE: begin
                     if (dp_stat.pos_one) begin
                        dp_cmd.act = ACT_DEL_TOP;
                     end else begin
                        dp_cmd.act = ACT_DEL_INIT;
                        state_in   = S_DEL_RD;
                     end
                  end
                  CMD_SEARCH: begin
                     dp_cmd.act = ACT_SCAN_INIT;
                     state_in   = S_SCAN_RD;
                  end
                  default: dp_cmd.act = ACT_NONE;
               endcase
            end
         end
         S_INS_RD: begin
            if (dp_stat.idx_ge_pos) begin
               dp_cmd.act = ACT_INS_RD;
               state_in   = S_INS_WR;
            end else begin
               dp_cmd.act = ACT_INS_PLACE;
               state_in   = S_TOP;
            end
         end
         S_INS_WR: begin
            dp_cmd.act = ACT_INS_WR;
            state_in   = S_INS_RD;
         end
         S_DEL_RD: begin
            if (dp_stat.idx_lt_count) begin
               dp_cmd.act = ACT_DEL_RD;
               state_in   = S_DEL_WR;
            end else begin
               dp_cmd.act = ACT_DEL_END;
               state_in   = S_TOP;
            end
         end
         S_DEL_WR: begin
            dp_cmd.act = ACT_DEL_WR;
            state_in   = S_DEL_RD;
         end
         S_SCAN_RD: begin
            if (dp_stat.idx_lt_count) begin
               dp_cmd.act = ACT_SCAN_RD;
               state_in   = S_SCAN_CMP;
            end else begin
               state_in   = S_TOP;
            end
         end
         S_SCAN_CMP: begin
            dp_cmd.act = ACT_SCAN_CMP;
            state_in   = S_SCAN_RD;
         end
         S_TOP: begin
            dp_cmd.act = ACT_TOP_RD;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (dp_stat.rsp_free) begin
               dp_cmd.act = ACT_RSP;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// File: src/pse_datapath.sv
`default_nettype none
module pse_datapath (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire        [pse_pkg::CMD_BITS-1:0]    req_command,
   input  wire signed [pse_pkg::VALUE_BITS-1:0]  req_value,
   input  wire        [pse_pkg::POS_BITS-1:0]    req_position,
   input  wire        [pse_pkg::AMT_BITS-1:0]    req_amount,
   input  pse_pkg::ctl_cmd_type                  dp_cmd,
   output pse_pkg::dp_stat_type                  dp_stat,
   pse_rsp_if.source                             rsp_chan
);
   import pse_pkg::*;

   logic [WORD_BITS-1:0]   entry_mem_ff [DEPTH];
   logic [WORD_BITS-1:0]   rd_data_ff;

   logic [CMD_BITS-1:0]    cmd_ff, cmd_in;
   logic [WORD_BITS-1:0]   val_ff, val_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [AMT_BITS-1:0]    amt_ff, amt_in;
   logic [POS_BITS-1:0]    shift_ff, shift_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic [CNT_BITS-1:0]    idx_ff, idx_in;
   status_type             status_ff, status_in;
   logic                   found_ff, found_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic                   rsp_found_ff, rsp_found_in;
   logic [COUNT_BITS-1:0]  rsp_count_ff, rsp_count_in;
   logic [VALUE_BITS-1:0]  rsp_top_ff, rsp_top_in;

   logic [CMP_BITS-1:0]    cnt_w, idx_w, pos_w, amt_w, req_pos_w;
   logic [CMP_BITS-1:0]    rd_idx, wr_idx;
   logic                   rd_en, wr_en;
   logic [WORD_BITS-1:0]   wr_data;
   status_type             chk_status;
   logic                   rsp_free;

   assign cnt_w     = CMP_BITS'(count_ff);
   assign idx_w     = CMP_BITS'(idx_ff);
   assign pos_w     = CMP_BITS'(pos_ff);
   assign amt_w     = CMP_BITS'(amt_ff);
   assign req_pos_w = CMP_BITS'(req_position);
   assign rsp_free  = !rsp_valid_ff || rsp_chan.ready;

   // checks for the incoming request against the current fill level
   always_comb begin
      chk_status = ST_OK;
      case (req_command)
         CMD_PUSH: begin
            if (cnt_w >= CMP_BITS'(DEPTH)) chk_status = ST_FULL;
         end
         CMD_POP: begin
            if (count_ff == '0) chk_status = ST_EMPTY;
         end
         CMD_INSERT: begin
            if (req_position == '0 || req_pos_w > cnt_w + CMP_BITS'(1)) begin
               chk_status = ST_BAD_POS;
            end else if (cnt_w >= CMP_BITS'(DEPTH)) begin
               chk_status = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (count_ff == '0) begin
               chk_status = ST_EMPTY;
            end else if (req_position == '0 || req_pos_w > cnt_w) begin
               chk_status = ST_BAD_POS;
            end
         end
         default: chk_status = ST_OK;
      endcase
   end

   always_comb begin
      dp_stat.cmd          = cmd_ff;
      dp_stat.ok           = (status_ff == ST_OK);
      dp_stat.pos_one      = (pos_w == CMP_BITS'(1));
      dp_stat.idx_ge_pos   = (idx_w >= pos_w);
      dp_stat.idx_lt_count = (idx_w < cnt_w);
      dp_stat.rsp_free     = rsp_free;
   end

   // memory port selection
   always_comb begin
      rd_en   = 1'b0;
      rd_idx  = idx_w;
      wr_en   = 1'b0;
      wr_idx  = idx_w;
      wr_data = rd_data_ff;
      case (dp_cmd.act) inside
         ACT_INS_RD: begin
            rd_en  = 1'b1;
            rd_idx = idx_w - CMP_BITS'(1);
         end
         ACT_DEL_RD, ACT_SCAN_RD: rd_en = 1'b1;
         ACT_TOP_RD: begin
            rd_en  = 1'b1;
            rd_idx = cnt_w - CMP_BITS'(1);
         end
         ACT_PUSH: begin
            wr_en   = 1'b1;
            wr_idx  = cnt_w;
            wr_data = val_ff;
         end
         ACT_INS_WR: wr_en = 1'b1;
         ACT_INS_PLACE: begin
            wr_en   = 1'b1;
            wr_data = val_ff;
         end
         ACT_DEL_WR: begin
            wr_en  = 1'b1;
            wr_idx = idx_w - CMP_BITS'(shift_ff);
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      amt_in        = amt_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      case (dp_cmd.act) inside
         ACT_LOAD: begin
            cmd_in    = req_command;
            val_in    = WORD_BITS'(req_value);
            pos_in    = req_position;
            amt_in    = req_amount;
            status_in = chk_status;
            found_in  = 1'b0;
         end
         ACT_PUSH, ACT_INS_PLACE: count_in = count_ff + CNT_BITS'(1);
         ACT_POP: count_in = count_ff - CNT_BITS'(1);
         ACT_DEL_TOP: begin
            count_in = (amt_w >= cnt_w) ? '0 : CNT_BITS'(cnt_w - amt_w);
         end
         ACT_INS_INIT: idx_in = count_ff;
         ACT_INS_WR: idx_in = idx_ff - CNT_BITS'(1);
         ACT_DEL_INIT: begin
            idx_in   = CNT_BITS'(pos_w);
            shift_in = (amt_ff > pos_ff) ? pos_ff : POS_BITS'(amt_ff);
         end
         ACT_DEL_WR, ACT_SCAN_RD: idx_in = idx_ff + CNT_BITS'(1);
         ACT_DEL_END: count_in = CNT_BITS'(cnt_w - CMP_BITS'(shift_ff));
         ACT_SCAN_INIT: idx_in = '0;
         ACT_SCAN_CMP: found_in = found_ff || (rd_data_ff == val_ff);
         ACT_RSP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_found_in  = found_ff;
            rsp_count_in  = COUNT_BITS'(count_ff);
            rsp_top_in    = (count_ff == '0) ? '0 : VALUE_BITS'(rd_data_ff);
         end
         default: cmd_in = cmd_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_idx[ADDR_BITS-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_idx[ADDR_BITS-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      amt_ff        <= amt_in;
      shift_ff      <= shift_in;
      idx_ff        <= idx_in;
      status_ff     <= status_in;
      found_ff      <= found_in;
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_top_ff    <= rsp_top_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.entry_count = rsp_count_ff;
   assign rsp_chan.top_value   = rsp_top_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_w <= CMP_BITS'(DEPTH))
      else $error("fill count above depth");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> wr_idx < CMP_BITS'(DEPTH))
      else $error("store write outside depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.act == ACT_PUSH |=> count_ff == $past(count_ff) + CNT_BITS'(1))
      else $error("push did not grow the stack");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.act == ACT_RSP |=> rsp_valid_ff && rsp_count_ff == COUNT_BITS'($past(count_ff)))
      else $error("response register not loaded");

endmodule
`default_nettype wire

// File: src/positional_stack_editor_unit.sv
`default_nettype none
// channel    dir   handshake      payload
// req_chan   in    valid/ready    command, value, position, amount
// rsp_chan   out   valid/ready    status, found, entry_count, top_value
//
// one request at a time; push, pop and failed requests load, execute,
// read the top and respond; insert at p and delete at p move m entries,
// each by a read then a write; search reads then compares n entries;
// a held response stalls the unit until taken; requests wait meanwhile
// synchronous reset empties the stack, store contents are not cleared
module positional_stack_editor_unit (
   input  wire       clock,
   input  wire       reset,
   pse_req_if.sink   req_chan,
   pse_rsp_if.source rsp_chan
);
   import pse_pkg::*;

   ctl_cmd_type dp_cmd;
   dp_stat_type dp_stat;
   logic        req_ready;

   assign req_chan.ready = req_ready;

   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   pse_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_command  (req_chan.command),
      .req_value    (req_chan.value),
      .req_position (req_chan.position),
      .req_amount   (req_chan.amount),
      .dp_cmd       (dp_cmd),
      .dp_stat      (dp_stat),
      .rsp_chan     (rsp_chan)
   );

endmodule
`default_nettype wire
